// File: rtl/opke_pkg.sv
package opke_pkg;

  // widest pad count needed over the supported group lengths
  localparam int CNT_W = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;

  typedef enum logic [2:0] {
    ACT_INT32  = 3'd0,
    ACT_INT64  = 3'd1,
    ACT_FLOAT  = 3'd2,
    ACT_DOUBLE = 3'd3,
    ACT_STRING = 3'd4,
    ACT_EMPTY  = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] value;
    logic [7:0]  data_byte;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } result_t;

  // one classified item: leading word bytes, then zero padding, then an optional marker
  typedef struct packed {
    logic [63:0]      word;
    logic [3:0]       word_cnt;
    logic [CNT_W-1:0] pad_cnt;
    logic             has_marker;
    logic [7:0]       marker;
  } cmd_t;

endpackage

// File: rtl/opke_front.sv
module opke_front
  import opke_pkg::*;
#(
  parameter int GROUP_LENGTH = 9
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  input  logic  q_full,
  output logic  full,
  output logic  q_push,
  output cmd_t  q_data
);

  localparam int FILL_W = $clog2(GROUP_LENGTH);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(GROUP_LENGTH - 1);
  localparam logic [31:0] SIGN32 = 32'h8000_0000;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  function automatic logic [31:0] float_key(input logic [31:0] b);
    logic is_nan;
    logic is_zero;
    is_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    is_zero = (b[30:0] == 31'd0);
    if (!is_nan && (is_zero || !b[31])) begin
      return b | SIGN32;
    end
    return ~b;
  endfunction

  function automatic logic [63:0] double_key(input logic [63:0] b);
    logic is_nan;
    logic is_zero;
    is_nan  = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    is_zero = (b[62:0] == 63'd0);
    if (!is_nan && (is_zero || !b[63])) begin
      return b | SIGN64;
    end
    return ~b;
  endfunction

  logic [FILL_W-1:0] group_fill;
  logic [FILL_W-1:0] group_fill_next;
  logic [FILL_W-1:0] fill_inc;
  logic              accept;
  logic              known;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && known;

  always_comb begin
    q_data          = '0;
    known           = 1'b1;
    group_fill_next = group_fill;
    // a group already at its limit restarts one short so the increment lands on the limit
    fill_inc = ((group_fill >= FILL_MAX) ? (FILL_MAX - FILL_W'(1)) : group_fill) + FILL_W'(1);
    case (item.action)
      ACT_INT32: begin
        q_data.word     = {item.value[31:0] ^ SIGN32, 32'd0};
        q_data.word_cnt = 4'd4;
      end
      ACT_INT64: begin
        q_data.word     = item.value ^ SIGN64;
        q_data.word_cnt = 4'd8;
      end
      ACT_FLOAT: begin
        q_data.word     = {float_key(item.value[31:0]), 32'd0};
        q_data.word_cnt = 4'd4;
      end
      ACT_DOUBLE: begin
        q_data.word     = double_key(item.value);
        q_data.word_cnt = 4'd8;
      end
      ACT_STRING: begin
        q_data.word     = {item.data_byte, 56'd0};
        q_data.word_cnt = 4'd1;
        group_fill_next = fill_inc;
        if (item.last_byte) begin
          q_data.pad_cnt    = CNT_W'(FILL_MAX - fill_inc);
          q_data.has_marker = 1'b1;
          q_data.marker     = 8'(fill_inc);
          group_fill_next   = '0;
        end else if (fill_inc == FILL_MAX) begin
          q_data.has_marker = 1'b1;
          q_data.marker     = 8'(GROUP_LENGTH);
          group_fill_next   = '0;
        end
      end
      ACT_EMPTY: begin
        q_data.pad_cnt    = CNT_W'(GROUP_LENGTH - 1);
        q_data.has_marker = 1'b1;
        group_fill_next   = '0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_fill <= '0;
    end else if (accept) begin
      group_fill <= group_fill_next;
    end
  end

  a_fill_below_limit: assert property (@(posedge clk) disable iff (rst)
    group_fill < FILL_MAX)
    else $error("group fill reached the group limit");

endmodule

// File: rtl/opke_queue.sv
module opke_queue
  import opke_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic empty,
  output logic full
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: rtl/opke_back.sv
module opke_back
  import opke_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  cmd_t    q_data,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  cmd_t    cur;
  cmd_t    step;
  logic    cur_valid;
  logic    out_valid;
  result_t out_data;
  logic [7:0] next_byte;
  logic    advance;
  logic    done;
  logic    finish;
  logic    load;

  assign empty   = !out_valid;
  assign result  = out_data;
  assign advance = cur_valid && (!out_valid || pop);

  // byte order: word bytes from the top, then zero padding, then the marker
  always_comb begin
    step = cur;
    if (cur.word_cnt != 4'd0) begin
      next_byte     = cur.word[63:56];
      step.word     = {cur.word[55:0], 8'd0};
      step.word_cnt = cur.word_cnt - 4'd1;
    end else if (cur.pad_cnt != '0) begin
      next_byte    = 8'd0;
      step.pad_cnt = cur.pad_cnt - CNT_W'(1);
    end else begin
      next_byte       = cur.marker;
      step.has_marker = 1'b0;
    end
  end

  assign done   = (step.word_cnt == 4'd0) && (step.pad_cnt == '0) && !step.has_marker;
  assign finish = advance && done;
  assign load   = !q_empty && (!cur_valid || finish);
  assign q_pop  = load;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end else if (advance) begin
      cur <= step;
    end
    if (advance) begin
      out_data.out_byte <= next_byte;
      out_data.run_last <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command taken from an empty queue");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    finish && q_empty |=> !cur_valid)
    else $error("command still active after its final byte");

endmodule

// File: rtl/order_preserving_key_encoder.sv
// order-preserving key encoder
// input channel: an item (action, value, data_byte, last_byte) transfers on a rising
// edge with push high and full low; items may follow in consecutive cycles.
// numeric actions produce 4 (int32, float) or 8 (int64, double) bytes, big-endian.
// string bytes arrive one per item; each full group of GROUP_LENGTH-1 data bytes is
// closed by a continue marker, and the last byte closes its group with zero padding
// and a marker holding the group's data count. an empty string gives a zero group
// with marker 0. unused action codes are taken and produce nothing.
// result channel: the oldest byte sits on result while empty is low and transfers on
// a rising edge with pop high; run_last marks the final byte of each input item.
// when idle, an item's first byte passes the command queue, command register and output register.
// throughput: one result byte per cycle while pop stays high, set by the byte sequencer in the
// back end; an item holds the sequencer until its last byte, and a two-entry command queue
// lets the front keep taking items while the back is busy.
// when pop stays low the output register holds, the sequencer stops, the queue fills
// and full rises; nothing is dropped.
// reset (synchronous, rst high) empties the queue and output and clears group state.
module order_preserving_key_encoder
  import opke_pkg::*;
#(
  parameter int GROUP_LENGTH = 9
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  cmd_t fq_data;
  cmd_t qb_data;
  logic fq_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  opke_front #(
    .GROUP_LENGTH(GROUP_LENGTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .full   (full),
    .q_push (fq_push),
    .q_data (fq_data)
  );

  opke_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_data),
    .pop   (q_pop),
    .rdata (qb_data),
    .empty (q_empty),
    .full  (q_full)
  );

  opke_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (qb_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// File: bench/order_preserving_key_encoder_tb.sv
`timescale 1ns / 100ps

module order_preserving_key_encoder_tb;
  import opke_pkg::*;

  localparam int GROUP_LEN = 9;
  localparam logic [31:0] SIGN32 = 32'h8000_0000;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [2:0] ACT_RESERVED_A = 3'd6;
  localparam logic [2:0] ACT_RESERVED_B = 3'd7;
  localparam int RANDOM_KEYS = 500;

  // one line of the directed table; typed rows carry their encoding right-aligned
  typedef struct packed {
    item_t       it;
    logic        typed;
    logic [3:0]  n;
    logic [71:0] bytes;
  } row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  item_t   item = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  logic [7:0]  key_bytes[$];
  result_t     expected_q[$];
  row_t        plan[$];
  int          str_fill = 0;
  int          errors = 0;
  int          bytes_seen = 0;
  int          act_count[8];
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  order_preserving_key_encoder #(
    .GROUP_LENGTH(GROUP_LEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d bytes still pending", expected_q.size());
    $display("** order_preserving_key_encoder: FAILED **");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] float_order(input logic [31:0] w);
    logic is_nan;
    logic is_zero;
    is_nan = (w[30:23] == 8'hFF) && (w[22:0] != '0);
    is_zero = (w[30:0] == '0);
    return (!is_nan && (is_zero || !w[31])) ? (w | SIGN32) : ~w;
  endfunction

  function automatic logic [63:0] double_order(input logic [63:0] w);
    logic is_nan;
    logic is_zero;
    is_nan = (w[62:52] == 11'h7FF) && (w[51:0] != '0);
    is_zero = (w[62:0] == '0);
    return (!is_nan && (is_zero || !w[63])) ? (w | SIGN64) : ~w;
  endfunction

  task automatic put_word(input logic [63:0] w, input int n);
    int k;
    for (k = n - 1; k >= 0; k--) key_bytes.push_back(w[8*k +: 8]);
  endtask

  // fills key_bytes with the encoding of one item and advances the string state
  task automatic encode_key(input item_t it);
    int k;
    key_bytes.delete();
    case (it.action)
      ACT_INT32:  put_word(64'(it.value[31:0] ^ SIGN32), 4);
      ACT_INT64:  put_word(it.value ^ SIGN64, 8);
      ACT_FLOAT:  put_word(64'(float_order(it.value[31:0])), 4);
      ACT_DOUBLE: put_word(double_order(it.value), 8);
      ACT_STRING: begin
        key_bytes.push_back(it.data_byte);
        if (str_fill >= GROUP_LEN - 1) str_fill = GROUP_LEN - 2;
        str_fill++;
        if (it.last_byte) begin
          for (k = str_fill; k < GROUP_LEN - 1; k++) key_bytes.push_back(8'h00);
          key_bytes.push_back(8'(str_fill));
          str_fill = 0;
        end else if (str_fill == GROUP_LEN - 1) begin
          key_bytes.push_back(8'(GROUP_LEN));
          str_fill = 0;
        end
      end
      ACT_EMPTY: begin
        repeat (GROUP_LEN) key_bytes.push_back(8'h00);
        str_fill = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_key(input row_t r);
    int k;
    int unsigned gap;
    push <= 1'b1;
    item <= r.it;
    do @(posedge clk); while (full);
    encode_key(r.it);
    if (r.typed) begin
      key_bytes.delete();
      for (k = 0; k < r.n; k++) key_bytes.push_back(r.bytes[8*(r.n-1-k) +: 8]);
    end
    for (k = 0; k < key_bytes.size(); k++)
      expected_q.push_back('{out_byte: key_bytes[k], run_last: (k == key_bytes.size() - 1)});
    act_count[r.it.action]++;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [2:0] action, input logic [63:0] value,
                         input logic [7:0] data, input logic last, input logic typed,
                         input int n, input logic [71:0] bytes);
    row_t r;
    r.it = '{action: action, value: value, data_byte: data, last_byte: last};
    r.typed = typed;
    r.n = 4'(n);
    r.bytes = bytes;
    plan.push_back(r);
  endtask

  function automatic logic [63:0] pick_number();
    logic [31:0] hi;
    hi = $urandom;
    case ($urandom_range(0, 19))
      0: return 64'h0;
      1: return {hi, SIGN32};
      2: return SIGN64;
      3: return '1;
      4: return {hi, 32'h7F80_0000};
      5: return {hi, 32'hFF80_0000};
      6: return {hi, hi[0], 8'hFF, 23'($urandom)};
      7: return {hi[0], 11'h7FF, 52'({$urandom, $urandom})};
      8: return 64'h7FF0_0000_0000_0000;
      9: return {hi, 32'h7FFF_FFFF};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic check_byte(input result_t got);
    result_t want;
    bytes_seen++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: byte %02h (last %0b) arrived with nothing pending",
                 $time, got.out_byte, got.run_last);
    end else begin
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: expected byte %02h last %0b, got byte %02h last %0b", $time,
                   want.out_byte, want.run_last, got.out_byte, got.run_last);
      end
    end
  endtask

  // output side: random stalls, none started while steady
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_byte(result);
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  initial begin
    row_t r;
    int   keys_sent;
    int   str_left;
    int   roll;
    int   k;

    add_row(ACT_INT32, 64'h0, 8'h00, 1'b0, 1'b1, 4, 72'h8000_0000);
    add_row(ACT_INT32, 64'hFFFF_FFFF_7FFF_FFFF, 8'hFF, 1'b1, 1'b1, 4, 72'hFFFF_FFFF);
    add_row(ACT_INT64, 64'h0, 8'h00, 1'b0, 1'b1, 8, 72'h8000_0000_0000_0000);
    add_row(ACT_INT64, '1, 8'hFF, 1'b1, 1'b1, 8, 72'h7FFF_FFFF_FFFF_FFFF);
    // negative zero encodes like positive zero
    add_row(ACT_FLOAT, 64'h0000_0000_8000_0000, 8'hFF, 1'b1, 1'b1, 4, 72'h8000_0000);
    // nan with the sign clear is still inverted
    add_row(ACT_FLOAT, 64'h0000_0000_7FC0_0000, 8'h00, 1'b0, 1'b1, 4, 72'h803F_FFFF);
    add_row(ACT_FLOAT, 64'hFFFF_FFFF_FF80_0000, 8'h00, 1'b0, 1'b1, 4, 72'h007F_FFFF);
    add_row(ACT_DOUBLE, SIGN64, 8'h00, 1'b0, 1'b1, 8, 72'h8000_0000_0000_0000);
    add_row(ACT_DOUBLE, '1, 8'h00, 1'b0, 1'b1, 8, 72'h0);
    add_row(ACT_RESERVED_A, 64'h0, 8'h00, 1'b0, 1'b1, 0, 72'h0);
    add_row(ACT_RESERVED_B, '1, 8'hFF, 1'b1, 1'b1, 0, 72'h0);
    add_row(ACT_EMPTY, '1, 8'hFF, 1'b1, 1'b1, 9, 72'h0);
    add_row(ACT_STRING, 64'h0, 8'hFF, 1'b1, 1'b0, 0, 72'h0);
    add_row(ACT_STRING, '1, 8'h00, 1'b0, 1'b0, 0, 72'h0);
    // numeric key inside an open string, then an empty string abandons it
    add_row(ACT_INT32, 64'h1234_5678, 8'h00, 1'b0, 1'b0, 0, 72'h0);
    add_row(ACT_EMPTY, 64'h0, 8'h00, 1'b0, 1'b1, 9, 72'h0);
    for (k = 0; k < GROUP_LEN - 1; k++)
      add_row(ACT_STRING, 64'h0, 8'(8'hA0 + k), 1'b0, 1'b0, 0, 72'h0);
    add_row(ACT_STRING, 64'h0, 8'h5A, 1'b1, 1'b0, 0, 72'h0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_key(plan[i]);

    keys_sent = 0;
    str_left = 0;
    while (keys_sent < RANDOM_KEYS) begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      r.typed = 1'b0;
      r.n = '0;
      r.bytes = '0;
      r.it.value = {$urandom, $urandom};
      r.it.data_byte = 8'($urandom);
      r.it.last_byte = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (str_left > 0) begin
        if (roll < 90) begin
          r.it.action = ACT_STRING;
          str_left--;
          r.it.last_byte = (str_left == 0);
        end else if (roll < 93) begin
          r.it.action = ACT_EMPTY;
          str_left = 0;
        end else if (roll < 95) begin
          r.it.action = $urandom_range(0, 1) ? ACT_RESERVED_A : ACT_RESERVED_B;
        end else begin
          r.it.action = 3'($urandom_range(int'(ACT_INT32), int'(ACT_DOUBLE)));
          r.it.value = pick_number();
        end
      end else if (roll < 40) begin
        // open a string; mostly within one or two groups, sometimes long
        str_left = ($urandom_range(0, 9) == 0) ? $urandom_range(GROUP_LEN, 3 * GROUP_LEN)
                                                : $urandom_range(1, GROUP_LEN);
        continue;
      end else if (roll < 48) begin
        r.it.action = ACT_EMPTY;
      end else if (roll < 52) begin
        r.it.action = $urandom_range(0, 1) ? ACT_RESERVED_A : ACT_RESERVED_B;
      end else begin
        r.it.action = 3'($urandom_range(int'(ACT_INT32), int'(ACT_DOUBLE)));
        r.it.value = pick_number();
      end
      send_key(r);
      if (r.it.action != ACT_RESERVED_A && r.it.action != ACT_RESERVED_B) keys_sent++;
    end

    push <= 1'b0;
    steady = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("keys: %0d int32, %0d int64, %0d float, %0d double, %0d string bytes, %0d empty",
             act_count[ACT_INT32], act_count[ACT_INT64], act_count[ACT_FLOAT],
             act_count[ACT_DOUBLE], act_count[ACT_STRING], act_count[ACT_EMPTY]);
    $display("%0d unused actions, %0d encoded bytes checked, %0d errors",
             act_count[ACT_RESERVED_A] + act_count[ACT_RESERVED_B], bytes_seen, errors);
    if (errors == 0) begin
      $display("** order_preserving_key_encoder: PASSED **");
    end else begin
      $display("** order_preserving_key_encoder: FAILED **");
    end
    $finish;
  end

endmodule
